// ===== hdl/rlbd_pkg.sv =====
package rlbd_pkg;

	// Widest result word, in byte lanes, and the width of one lane.
	localparam int MAX_LANES = 8;
	localparam int LANE_W = 8;

	// Default number of lanes that a repeat run fills per result word.
	localparam int OUT_LANES = 8;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_start;
	} rlbd_in_t;

	typedef struct packed {
		logic [MAX_LANES*LANE_W-1:0] out_bytes;
		logic [3:0]                  out_count;
		logic                        run_last;
	} rlbd_out_t;

	// Control from the parser to the run unit.
	typedef struct packed {
		logic load;
		logic step;
	} run_ctrl_t;

endpackage

// ===== hdl/rlbd_run_unit.sv =====
module rlbd_run_unit #(
	parameter int LANES = rlbd_pkg::OUT_LANES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlbd_pkg::run_ctrl_t ctrl,
	input  logic [7:0]          load_byte,
	input  logic [7:0]          load_count,
	output rlbd_pkg::rlbd_out_t word
);

	localparam logic [3:0] LANES_C = 4'(LANES);

	logic [7:0] left_q;
	logic [7:0] byte_q;
	logic       fits;
	logic [3:0] take;

	// One compare and one subtract per result word.
	assign fits = left_q <= {4'b0000, LANES_C};
	assign take = fits ? left_q[3:0] : LANES_C;

	always_comb begin
		word.out_bytes = '0;
		for (int i = 0; i < rlbd_pkg::MAX_LANES; i++) begin
			if (4'(i) < take) begin
				word.out_bytes[i*rlbd_pkg::LANE_W +: rlbd_pkg::LANE_W] = byte_q;
			end
		end
		word.out_count = take;
		word.run_last = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			byte_q <= '0;
		end else if (ctrl.load) begin
			left_q <= load_count;
			byte_q <= load_byte;
		end else if (ctrl.step) begin
			left_q <= left_q - {4'b0000, take};
		end
	end

endmodule

// ===== hdl/run_length_byte_decoder_top.sv =====
// Run-length byte decoder. Compressed bytes enter on the in channel, one
// transaction per byte, and decompressed data leaves on the out channel as
// words of up to OUT_LANES bytes with a byte count and a run_last mark.
// cfg_wr_en/cfg_wr_data write the scheme bit: 0 escape style, 1 byte-run
// style; it is consulted only when a header byte is parsed.
// Header and count bytes give no result. A literal byte's word is
// registered and is on the out channel in the cycle after the byte is
// accepted. A repeat value byte that asks for n bytes loads the run unit,
// which produces one word per cycle while the receiver does not stall,
// with a compare and a subtract of the remaining count, and the input
// stalls until the last word of the run is loaded into the output register.
// A transaction with frame_start set drops any open sequence and is parsed
// as a header. When the receiver stalls, the output register holds its word
// and both the run unit and the input channel wait.
// Reset clears the parser to expect a header, empties the output register
// and sets the scheme bit to byte-run style.
module run_length_byte_decoder_top #(
	parameter int OUT_LANES = rlbd_pkg::OUT_LANES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rlbd_pkg::rlbd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rlbd_pkg::rlbd_out_t out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);

	localparam logic [3:0] LANES_C = 4'(OUT_LANES);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_COUNT,
		PH_LITERAL,
		PH_REPEAT
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [7:0]          remain_q;
	logic                mode_q;
	logic                out_valid_q;
	rlbd_pkg::rlbd_out_t out_data_q;

	phase_t              cur_phase;
	phase_t              nxt_phase;
	logic [7:0]          cur_rem;
	logic [7:0]          nxt_rem;
	logic                lit_emit;
	logic                run_start;
	logic                accept;
	logic                out_free;
	rlbd_pkg::run_ctrl_t run_ctrl;
	rlbd_pkg::rlbd_out_t run_word;

	// The output register can take a word when it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept = in_valid && !in_stall;

	// Parse one byte. A frame start forces the header phase first.
	always_comb begin
		cur_phase = in_data.frame_start ? PH_HEADER : phase_q;
		cur_rem = in_data.frame_start ? 8'd0 : remain_q;
		nxt_phase = cur_phase;
		nxt_rem = cur_rem;
		lit_emit = 1'b0;
		run_start = 1'b0;
		unique case (cur_phase)
			PH_HEADER: begin
				if (!mode_q) begin
					if (in_data.in_byte == 8'd0) begin
						nxt_phase = PH_COUNT;
					end else begin
						nxt_rem = in_data.in_byte;
						nxt_phase = PH_REPEAT;
					end
				end else if (!in_data.in_byte[7]) begin
					nxt_rem = in_data.in_byte + 8'd1;
					nxt_phase = PH_LITERAL;
				end else begin
					nxt_rem = in_data.in_byte - 8'd127;
					nxt_phase = PH_REPEAT;
				end
			end
			PH_COUNT: begin
				if (in_data.in_byte == 8'd0) begin
					nxt_phase = PH_HEADER;
				end else begin
					nxt_rem = in_data.in_byte;
					nxt_phase = PH_LITERAL;
				end
			end
			PH_LITERAL: begin
				lit_emit = 1'b1;
				if (cur_rem <= 8'd1) begin
					nxt_rem = 8'd0;
					nxt_phase = PH_HEADER;
				end else begin
					nxt_rem = cur_rem - 8'd1;
				end
			end
			PH_REPEAT: begin
				// An empty run gives no words at all.
				run_start = cur_rem != 8'd0;
				nxt_rem = 8'd0;
				nxt_phase = PH_HEADER;
			end
		endcase
	end

	assign run_ctrl.load = accept && run_start;
	assign run_ctrl.step = (state_q == ST_EMIT) && out_free;

	rlbd_run_unit #(
		.LANES(OUT_LANES)
	) u_run (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (run_ctrl),
		.load_byte (in_data.in_byte),
		.load_count(cur_rem),
		.word      (run_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_HEADER;
			remain_q <= '0;
			mode_q <= 1'b1;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q <= nxt_phase;
				remain_q <= nxt_rem;
				if (run_start) begin
					state_q <= ST_EMIT;
				end
			end
			if (run_ctrl.step) begin
				out_data_q <= run_word;
				out_valid_q <= 1'b1;
				if (run_word.run_last) begin
					state_q <= ST_IDLE;
				end
			end else if (accept && lit_emit) begin
				out_data_q.out_bytes <= {{(rlbd_pkg::MAX_LANES*rlbd_pkg::LANE_W-8){1'b0}},
					in_data.in_byte};
				out_data_q.out_count <= 4'd1;
				out_data_q.run_last <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// No input is taken while a run is being expanded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> in_stall)
		else $error("input accepted during run expansion");

	// Every word carries between one and the configured number of bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_count != 4'd0) && (out_data.out_count <= LANES_C))
		else $error("output byte count out of range");

	// A word that is not full must close its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.out_count < LANES_C)) |-> out_data.run_last)
		else $error("short word without run_last");

	// A run word that is not the last keeps the sequencer expanding.
	assert property (@(posedge clk) disable iff (!arst_n)
		(run_ctrl.step && !run_word.run_last) |=> (state_q == ST_EMIT))
		else $error("run expansion ended early");

endmodule
